@@ hdl/smst_pkg.sv @@
`timescale 1ns / 1ps

package smst_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned OUT_CNT_W    = 5;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_COUNT  = 2'd2;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [WORD_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic                 success;
    logic [OUT_CNT_W-1:0] occurrences;
    logic [OUT_CNT_W-1:0] size;
    logic                 full_rejected;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_FIND,
    ST_SHIFT,
    ST_COUNT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RD_PREV,
    RD_HERE,
    RD_NEXT
  } rd_sel_e;

  typedef struct packed {
    logic    accept;
    logic    idx_load_fill;
    logic    idx_clr;
    logic    idx_inc;
    logic    idx_dec;
    logic    wr_shift;
    logic    wr_value;
    logic    fill_inc;
    logic    fill_dec;
    logic    occ_inc;
    logic    set_ok;
    logic    set_rej;
    rd_sel_e rd_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic idx_zero;
    logic at_end;
    logic shift_last;
    logic match;
    logic ord_e_v;
    logic ord_v_e;
  } ctrl_stat_t;

endpackage

@@ hdl/smst_ram.sv @@
`timescale 1ns / 1ps

module smst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/smst_ctrl.sv @@
`timescale 1ns / 1ps

module smst_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            in_command_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  smst_pkg::ctrl_stat_t  stat_i,
  output smst_pkg::ctrl_cmd_t   cmd_o
);

  import smst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.rd_sel = RD_HERE;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (in_command_i)
            CMD_ADD: begin
              if (stat_i.full) begin
                cmd_o.set_rej = 1'b1;
                state_d       = ST_DONE;
              end else begin
                cmd_o.idx_load_fill = 1'b1;
                cmd_o.rd_sel        = RD_PREV;
                state_d             = ST_ADD;
              end
            end
            CMD_REMOVE: begin
              cmd_o.idx_clr = 1'b1;
              state_d       = ST_FIND;
            end
            CMD_COUNT: begin
              cmd_o.idx_clr = 1'b1;
              state_d       = ST_COUNT;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_ADD: begin
        if (stat_i.idx_zero || stat_i.ord_e_v) begin
          cmd_o.wr_value = 1'b1;
          cmd_o.fill_inc = 1'b1;
          cmd_o.set_ok   = 1'b1;
          state_d        = ST_DONE;
        end else begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.idx_dec  = 1'b1;
          cmd_o.rd_sel   = RD_PREV;
        end
      end
      ST_FIND: begin
        if (stat_i.at_end) begin
          state_d = ST_DONE;
        end else if (stat_i.match) begin
          cmd_o.rd_sel = RD_NEXT;
          state_d      = ST_SHIFT;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (stat_i.shift_last) begin
          cmd_o.fill_dec = 1'b1;
          cmd_o.set_ok   = 1'b1;
          state_d        = ST_DONE;
        end else begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          cmd_o.rd_sel   = RD_NEXT;
        end
      end
      ST_COUNT: begin
        if (stat_i.at_end) begin
          state_d = ST_DONE;
        end else if (stat_i.match) begin
          cmd_o.occ_inc = 1'b1;
          cmd_o.idx_inc = 1'b1;
        end else if (stat_i.ord_v_e) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_put_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_value |-> !stat_i.full)
    else $error("value written into a full store");

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("result shown while taking a new word");
`endif

endmodule

@@ hdl/smst_dp.sv @@
`timescale 1ns / 1ps

module smst_dp #(
  parameter int unsigned Capacity = smst_pkg::CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  smst_pkg::in_word_t   in_word_i,
  input  smst_pkg::ctrl_cmd_t  cmd_i,
  output smst_pkg::ctrl_stat_t stat_o,
  output smst_pkg::out_word_t  out_word_o
);

  import smst_pkg::*;

  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW  = $clog2(Capacity + 1);

  logic                     order_q;
  logic signed [WORD_W-1:0] val_q;
  logic [CntW-1:0]          idx_q, idx_d;
  logic [CntW-1:0]          fill_q, fill_d;
  logic [CntW-1:0]          occ_q, occ_d;
  logic                     ok_q, rej_q;
  logic [CntW-1:0]          rd_idx;
  logic                     ram_we;
  logic [WORD_W-1:0]        ram_wdata;
  logic [WORD_W-1:0]        ram_rdata;
  logic signed [WORD_W-1:0] entry;
  logic [CntW:0]            idx_plus1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
      fill_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      val_q <= in_word_i.value;
    end
    idx_q <= idx_d;
    occ_q <= occ_d;
    ok_q  <= cmd_i.set_ok | cmd_i.occ_inc | (ok_q & !cmd_i.accept);
    rej_q <= cmd_i.set_rej | (rej_q & !cmd_i.accept);
  end

  always_comb begin
    priority if (cmd_i.idx_load_fill) begin
      idx_d = fill_q;
    end else if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CntW'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - CntW'(1);
    end else begin
      idx_d = idx_q;
    end

    priority if (cmd_i.fill_inc) begin
      fill_d = fill_q + CntW'(1);
    end else if (cmd_i.fill_dec) begin
      fill_d = fill_q - CntW'(1);
    end else begin
      fill_d = fill_q;
    end

    if (cmd_i.accept) begin
      occ_d = '0;
    end else if (cmd_i.occ_inc) begin
      occ_d = occ_q + CntW'(1);
    end else begin
      occ_d = occ_q;
    end

    unique case (cmd_i.rd_sel)
      RD_PREV: rd_idx = idx_d - CntW'(1);
      RD_NEXT: rd_idx = idx_d + CntW'(1);
      default: rd_idx = idx_d;
    endcase
  end

  assign ram_we    = cmd_i.wr_shift | cmd_i.wr_value;
  assign ram_wdata = cmd_i.wr_value ? val_q : ram_rdata;

  smst_ram #(
    .Width(WORD_W),
    .Depth(Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q[AddrW-1:0]),
    .wdata_i(ram_wdata),
    .raddr_i(rd_idx[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign entry     = $signed(ram_rdata);
  assign idx_plus1 = {1'b0, idx_q} + (CntW + 1)'(1);

  always_comb begin
    stat_o            = '0;
    stat_o.full       = (fill_q == CntW'(Capacity));
    stat_o.idx_zero   = (idx_q == '0);
    stat_o.at_end     = (idx_q >= fill_q);
    stat_o.shift_last = (idx_plus1 >= {1'b0, fill_q});
    stat_o.match      = (entry == val_q);
    stat_o.ord_e_v    = order_q ? (entry >= val_q) : (entry <= val_q);
    stat_o.ord_v_e    = order_q ? (val_q >= entry) : (val_q <= entry);
  end

  always_comb begin
    out_word_o               = '0;
    out_word_o.success       = ok_q;
    out_word_o.occurrences   = OUT_CNT_W'(occ_q);
    out_word_o.size          = OUT_CNT_W'(fill_q);
    out_word_o.full_rejected = rej_q;
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(Capacity))
    else $error("fill count above capacity");

  a_write_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (idx_q < CntW'(Capacity)) && (idx_q <= fill_q))
    else $error("entry write outside the stored range");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fill_inc || cmd_i.fill_dec) |=> fill_q != $past(fill_q))
    else $error("fill count did not move on add or remove");
`endif

endmodule

@@ hdl/sorted_multiset_store.sv @@
`timescale 1ns / 1ps
// The entry memory is read once per cycle and written at most once per cycle, one entry per step.
// A new word is taken the cycle after the previous result word is taken.
// Reset clears the fill count and selects ascending order.
// The entry memory is not cleared; entries past the fill count may be read, but their values are never used.

module sorted_multiset_store #(
  parameter int unsigned Capacity = smst_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  smst_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output smst_pkg::out_word_t out_word_o
);

  import smst_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  smst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_command_i(in_word_i.command),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  smst_dp #(
    .Capacity(Capacity)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_word_o (out_word_o)
  );

endmodule
